// ===== design/sfd_pkg.sv =====
// shared types, register codes and defaults of the stereo feedback delay
`default_nettype none

package sfd_pkg;

	// default sizes of the delay lines
	localparam int DEF_MAX_DELAY   = 65536;
	localparam int DEF_SAMPLE_BITS = 16;

	// configuration port widths
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// register reset values
	localparam logic [15:0] RST_DELAY    = 16'd24000;
	localparam logic [14:0] RST_FEEDBACK = 15'd16384;
	localparam logic [15:0] RST_WET      = 16'd16384;
	localparam logic        RST_STEREO   = 1'b1;
	localparam logic        RST_BYPASS   = 1'b0;

	// unity gain in Q1.15
	localparam logic [16:0] UNITY_Q15 = 17'd32768;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELAY    = 3'd0,
		REG_FEEDBACK = 3'd1,
		REG_WET      = 3'd2,
		REG_STEREO   = 3'd3,
		REG_BYPASS   = 3'd4
	} cfg_reg_t;

	// one stereo input pair
	typedef struct packed {
		logic signed [15:0] left_in;
		logic signed [15:0] right_in;
	} sample_t;

	// one stereo output pair
	typedef struct packed {
		logic signed [15:0] left_out;
		logic signed [15:0] right_out;
	} result_t;

	// settings as the datapath uses them, already clamped
	typedef struct packed {
		logic [15:0] delay;
		logic [14:0] feedback;
		logic [16:0] wet;
		logic        stereo;
		logic        bypass;
	} cfg_t;

endpackage

`default_nettype wire

// ===== design/sfd_cfg_regs.sv =====
// configuration registers with delay and wet clamping
`default_nettype none

module sfd_cfg_regs #(
	parameter int MAX_DELAY = sfd_pkg::DEF_MAX_DELAY
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_write,
	input  wire logic [sfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sfd_pkg::CFG_DATA_W-1:0] cfg_data,
	output sfd_pkg::cfg_t                       cfg
);

	logic [15:0] delay_q;
	logic [14:0] feedback_q;
	logic [15:0] wet_q;
	logic        stereo_q;
	logic        bypass_q;

	// register writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q    <= sfd_pkg::RST_DELAY;
			feedback_q <= sfd_pkg::RST_FEEDBACK;
			wet_q      <= sfd_pkg::RST_WET;
			stereo_q   <= sfd_pkg::RST_STEREO;
			bypass_q   <= sfd_pkg::RST_BYPASS;
		end else if (cfg_write) begin
			unique case (sfd_pkg::cfg_reg_t'(cfg_index))
				sfd_pkg::REG_DELAY:    delay_q    <= cfg_data[15:0];
				sfd_pkg::REG_FEEDBACK: feedback_q <= cfg_data[14:0];
				sfd_pkg::REG_WET:      wet_q      <= cfg_data[15:0];
				sfd_pkg::REG_STEREO:   stereo_q   <= cfg_data[0];
				sfd_pkg::REG_BYPASS:   bypass_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// zero delay acts as one, delay capped at line length, wet capped at unity
	always_comb begin
		if (delay_q == 16'd0) begin
			cfg.delay = 16'd1;
		end else if ({16'd0, delay_q} > 32'(MAX_DELAY)) begin
			cfg.delay = 16'(MAX_DELAY);
		end else begin
			cfg.delay = delay_q;
		end
		cfg.feedback = feedback_q;
		cfg.wet      = ({1'b0, wet_q} > sfd_pkg::UNITY_Q15) ? sfd_pkg::UNITY_Q15 : {1'b0, wet_q};
		cfg.stereo   = stereo_q;
		cfg.bypass   = bypass_q;
	end

endmodule

`default_nettype wire

// ===== design/sfd_line_ram.sv =====
// one delay line: simple dual-port memory with registered read
`default_nettype none

module sfd_line_ram #(
	parameter int DEPTH = sfd_pkg::DEF_MAX_DELAY,
	parameter int WIDTH = sfd_pkg::DEF_SAMPLE_BITS,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and read port, read returns old data on a collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/sfd_channel.sv =====
// per-channel arithmetic: feedback write value and wet/dry mix
`default_nettype none

module sfd_channel #(
	parameter int SAMPLE_BITS = sfd_pkg::DEF_SAMPLE_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          load_s2,
	input  wire logic signed [15:0]            in_s1,
	input  wire logic signed [SAMPLE_BITS-1:0] delayed_s1,
	input  wire logic        [14:0]            feedback,
	input  wire logic        [16:0]            wet,
	output logic      signed [SAMPLE_BITS-1:0] wdata,
	output logic      signed [15:0]            mix_out
);

	localparam int SB  = SAMPLE_BITS;
	localparam int FPW = SB + 16;
	localparam int FSW = ((SB + 2 > 16) ? SB + 2 : 16) + 1;
	localparam int PWW = SB + 18;
	localparam int MW  = ((PWW > 34) ? PWW : 34) + 2;

	logic signed [FPW-1:0] fb_prod;
	logic        [FPW:0]   fb_rnd;
	logic        [SB+1:0]  fb_sh;
	logic        [FSW-1:0] fb_sum;
	logic                  fb_fits;
	logic        [16:0]    dry;
	logic signed [PWW-1:0] wet_prod;
	logic signed [33:0]    dry_prod;
	logic signed [PWW-1:0] wet_prod_s2;
	logic signed [33:0]    dry_prod_s2;
	logic        [MW-1:0]  mix_sum;
	logic        [MW-16:0] mix_sh;
	logic                  mix_fits;
	logic        [SB-1:0]  mix_sat;
	logic        [SB+15:0] mix_ext;

	// feedback: round(delayed * gain), add input, saturate to sample range
	assign fb_prod = delayed_s1 * $signed({1'b0, feedback});
	assign fb_rnd  = {fb_prod[FPW-1], fb_prod} + (FPW+1)'(16384);
	assign fb_sh   = fb_rnd[FPW:15];
	assign fb_sum  = {{(FSW-SB-2){fb_sh[SB+1]}}, fb_sh} + {{(FSW-16){in_s1[15]}}, in_s1};
	assign fb_fits = (&fb_sum[FSW-1:SB-1]) | ~(|fb_sum[FSW-1:SB-1]);
	assign wdata   = fb_fits ? fb_sum[SB-1:0] : {fb_sum[FSW-1], {(SB-1){~fb_sum[FSW-1]}}};

	// mix products
	assign dry      = sfd_pkg::UNITY_Q15 - wet;
	assign wet_prod = delayed_s1 * $signed({1'b0, wet});
	assign dry_prod = in_s1 * $signed({1'b0, dry});

	always_ff @(posedge clk) begin
		if (load_s2) begin
			wet_prod_s2 <= wet_prod;
			dry_prod_s2 <= dry_prod;
		end
	end

	// mix sum, round half up, saturate, fit to 16 bits
	assign mix_sum  = {{(MW-PWW){wet_prod_s2[PWW-1]}}, wet_prod_s2}
		+ {{(MW-34){dry_prod_s2[33]}}, dry_prod_s2} + MW'(16384);
	assign mix_sh   = mix_sum[MW-1:15];
	assign mix_fits = (&mix_sh[MW-16:SB-1]) | ~(|mix_sh[MW-16:SB-1]);
	assign mix_sat  = mix_fits ? mix_sh[SB-1:0] : {mix_sh[MW-16], {(SB-1){~mix_sh[MW-16]}}};
	assign mix_ext  = {{16{mix_sat[SB-1]}}, mix_sat};
	assign mix_out  = mix_ext[15:0];

endmodule

`default_nettype wire

// ===== design/stereo_feedback_delay.sv =====
// Stereo feedback delay with wet/dry mix, top level.
// Input channel sample (valid/ready) carries one stereo pair per transfer;
// output channel result (valid/ready) returns one mixed pair per input pair,
// in order. Settings are written through cfg_write/cfg_index/cfg_data; the user
// must write them only while no transfer is in flight, the block does not enforce it.
// Throughput: one pair per clock cycle while the receiver takes results, set by
// the single read and single write port of each line memory and by the
// combinational feedback multiply-add that lets a one-sample delay run without a bubble.
// A pair is read from memory at the edge that accepts it, then passes through
// feedback and products into stage 2, then the mix into the output register.
// A result that the receiver does not take stays in the output register;
// the pipeline keeps filling behind it and sample_ready drops only when all
// three stages are full.
// Reset clears the settings to defaults, the write pointer and the fill
// count; lines are not swept: an entry not yet written since reset reads as
// zero through the fill count, so the block is ready right after reset.
`default_nettype none

module stereo_feedback_delay #(
	parameter int MAX_DELAY   = sfd_pkg::DEF_MAX_DELAY,
	parameter int SAMPLE_BITS = sfd_pkg::DEF_SAMPLE_BITS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           sample_valid,
	output logic                                sample_ready,
	input  wire sfd_pkg::sample_t               sample,
	output logic                                result_valid,
	input  wire logic                           result_ready,
	output sfd_pkg::result_t                    result,
	input  wire logic                           cfg_write,
	input  wire logic [sfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sfd_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int SB   = SAMPLE_BITS;
	localparam int AW   = $clog2(MAX_DELAY);
	localparam int PW   = ((AW > 16) ? AW : 16) + 1;
	localparam int CNTW = AW + 1;

	sfd_pkg::cfg_t cfg;

	// pointer, fill count
	logic [AW-1:0]   wp_q;
	logic [CNTW-1:0] fill_q;
	logic [PW-1:0]   wp_x;
	logic [PW-1:0]   d_x;
	logic [PW-1:0]   rd_x;
	logic [AW-1:0]   rd_addr;
	logic            rd_live;
	logic            hit_next;
	logic            wp_last;

	// handshake
	logic sample_acc;
	logic s1_adv;
	logic s2_adv;
	logic mem_we;

	// stage 1
	logic                 s1_valid_q;
	logic signed [15:0]   l_s1;
	logic signed [15:0]   r_s1;
	logic [AW-1:0]        waddr_s1;
	logic                 hit_s1;
	logic                 live_s1;
	logic [SB-1:0]        rdl;
	logic [SB-1:0]        rdr;
	logic signed [SB-1:0] fwd_l_q;
	logic signed [SB-1:0] fwd_r_q;
	logic signed [SB-1:0] delayed_l;
	logic signed [SB-1:0] delayed_r;
	logic signed [15:0]   r_line;
	logic signed [SB-1:0] wdata_l;
	logic signed [SB-1:0] wdata_r;

	// stage 2 and output
	logic                 s2_valid_q;
	logic signed [15:0]   l_s2;
	logic signed [15:0]   r_s2;
	logic signed [15:0]   mix_l;
	logic signed [15:0]   mix_r;
	logic                 result_valid_q;
	sfd_pkg::result_t     result_q;

	sfd_cfg_regs #(
		.MAX_DELAY (MAX_DELAY)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// elastic pipeline control
	assign s2_adv       = !result_valid_q || result_ready;
	assign s1_adv       = !s2_valid_q || s2_adv;
	assign sample_ready = !s1_valid_q || s1_adv;
	assign sample_acc   = sample_valid && sample_ready;
	assign mem_we       = s1_valid_q && s1_adv && !cfg.bypass;

	// read address: write pointer minus delay, modulo line length
	assign wp_x    = PW'(wp_q);
	assign d_x     = PW'(cfg.delay);
	assign rd_x    = (wp_x >= d_x) ? (wp_x - d_x) : (wp_x + PW'(MAX_DELAY) - d_x);
	assign rd_addr = rd_x[AW-1:0];
	assign rd_live = {1'b0, rd_addr} < fill_q;
	assign wp_last = (wp_q == AW'(MAX_DELAY - 1));

	// entry being written by the stage 1 item this very edge
	assign hit_next = s1_valid_q && !cfg.bypass && (rd_addr == waddr_s1);

	// write pointer advances on each non-bypass transfer, fill count too until it reaches the line length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (sample_acc && !cfg.bypass) begin
			wp_q <= wp_last ? '0 : wp_q + AW'(1);
			if (fill_q != CNTW'(MAX_DELAY)) begin
				fill_q <= fill_q + CNTW'(1);
			end
		end
	end

	sfd_line_ram #(
		.DEPTH (MAX_DELAY),
		.WIDTH (SB),
		.AW    (AW)
	) u_left_line (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr_s1),
		.wdata (wdata_l),
		.re    (sample_acc),
		.raddr (rd_addr),
		.rdata (rdl)
	);

	sfd_line_ram #(
		.DEPTH (MAX_DELAY),
		.WIDTH (SB),
		.AW    (AW)
	) u_right_line (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr_s1),
		.wdata (wdata_r),
		.re    (sample_acc),
		.raddr (rd_addr),
		.rdata (rdr)
	);

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (sample_ready) begin
			s1_valid_q <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_acc) begin
			l_s1     <= sample.left_in;
			r_s1     <= sample.right_in;
			waddr_s1 <= wp_q;
			hit_s1   <= hit_next;
			live_s1  <= rd_live;
		end
		if (mem_we) begin
			fwd_l_q <= wdata_l;
			fwd_r_q <= wdata_r;
		end
	end

	// delayed sample: forwarded write, memory, or zero if never written
	always_comb begin
		if (hit_s1) begin
			delayed_l = fwd_l_q;
			delayed_r = fwd_r_q;
		end else if (live_s1) begin
			delayed_l = $signed(rdl);
			delayed_r = $signed(rdr);
		end else begin
			delayed_l = '0;
			delayed_r = '0;
		end
	end

	// mono feeds the right line from the left input
	assign r_line = cfg.stereo ? r_s1 : l_s1;

	sfd_channel #(
		.SAMPLE_BITS (SB)
	) u_left_chan (
		.clk        (clk),
		.load_s2    (s1_valid_q && s1_adv),
		.in_s1      (l_s1),
		.delayed_s1 (delayed_l),
		.feedback   (cfg.feedback),
		.wet        (cfg.wet),
		.wdata      (wdata_l),
		.mix_out    (mix_l)
	);

	sfd_channel #(
		.SAMPLE_BITS (SB)
	) u_right_chan (
		.clk        (clk),
		.load_s2    (s1_valid_q && s1_adv),
		.in_s1      (r_line),
		.delayed_s1 (delayed_r),
		.feedback   (cfg.feedback),
		.wet        (cfg.wet),
		.wdata      (wdata_r),
		.mix_out    (mix_r)
	);

	// stage 2 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s1_adv) begin
			s2_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q && s1_adv) begin
			l_s2 <= l_s1;
			r_s2 <= r_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (s2_adv) begin
			result_valid_q <= s2_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_valid_q && s2_adv) begin
			if (cfg.bypass) begin
				result_q.left_out  <= l_s2;
				result_q.right_out <= r_s2;
			end else begin
				result_q.left_out  <= mix_l;
				result_q.right_out <= cfg.stereo ? mix_r : 16'sd0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	// pointer moves by one, wrapping at the line length
	a_wp_step: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_acc && !cfg.bypass) |=>
		(wp_q == (($past(wp_q) == AW'(MAX_DELAY - 1)) ? '0 : $past(wp_q) + AW'(1))))
		else $error("write pointer did not advance by one");

	// fill count never passes the line length
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNTW'(MAX_DELAY))
		else $error("fill count beyond line length");

	// a forwarded entry is written at the same edge that reads it
	a_fwd_write: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_acc && hit_next) |-> mem_we)
		else $error("forward hit without a write");

	// input stalls only when the output is full and stalled
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> (result_valid_q && !result_ready && s1_valid_q && s2_valid_q))
		else $error("input stalled without a full pipeline");
`endif

endmodule

`default_nettype wire
